// File: rtl/kmh_pkg.sv
// Package for the k-mer minimum anchor hash block.
// Holds the item and queue types, the hash and mixer constants and the window helpers.
// No dependencies.
package kmh_pkg;

  localparam int MAX_WINDOW  = 12;
  localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0]  KMER_RESET  = 4'd12;
  localparam logic [63:0] POLY_BASE   = 64'd1099511628211;
  localparam int          POLY_SHIFT  = 40;
  localparam logic [8:0]  POLY_LOW    = 9'd435;
  localparam logic [63:0] MIX_MUL_A   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B   = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT_A = 33;
  localparam int          MIX_SHIFT_B = 29;

  typedef struct packed {
    logic [7:0] residue;
    logic       last_residue;
  } item_t;

  typedef struct packed {
    logic [63:0] anchor_hash;
    logic        anchor_usable;
  } result_t;

  typedef struct packed {
    logic [7:0] residue;
    logic [7:0] old_residue;
    logic       drop;
    logic       full;
    logic       last;
  } task_t;

  function automatic logic [MAX_WINDOW-1:0][63:0] build_drop_table();
    logic [MAX_WINDOW-1:0][63:0] t;
    logic [63:0] w;
    w = 64'd1;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      t[i] = w;
      w = w * POLY_BASE;
    end
    return t;
  endfunction

  localparam logic [MAX_WINDOW-1:0][63:0] DROP_TABLE = build_drop_table();

  function automatic logic [CNT_W-1:0] eff_k(input logic [3:0] v);
    if (v == 4'd0) begin
      return CNT_W'(1);
    end
    if (int'(v) > MAX_WINDOW) begin
      return CNT_W'(MAX_WINDOW);
    end
    return CNT_W'(v);
  endfunction

  function automatic logic [63:0] drop_weight_of(input logic [3:0] v);
    logic [CNT_W-1:0] k;
    k = eff_k(v);
    return DROP_TABLE[IDX_W'(k - CNT_W'(1))];
  endfunction

endpackage

// File: rtl/kmh_front.sv
// Front end: accepts residues, keeps the window store and byte count, classifies each item.
// Pushes one task per residue into the queue. Depends on kmh_pkg.
module kmh_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_write,
  input  logic [3:0]     cfg_data,
  input  logic           item_valid,
  output logic           item_stall,
  input  kmh_pkg::item_t item,
  output logic           task_valid,
  input  logic           task_ready,
  output kmh_pkg::task_t task_data
);
  import kmh_pkg::*;

  logic [3:0]       kmer_length;
  logic [CNT_W-1:0] seen;
  logic [7:0]       window [MAX_WINDOW];
  logic [CNT_W-1:0] k;
  logic             sat;
  logic             accept;

  assign k          = eff_k(kmer_length);
  assign sat        = (seen >= k);
  assign accept     = item_valid && task_ready;
  assign item_stall = !task_ready;
  assign task_valid = accept;

  always_comb begin
    task_data.residue     = item.residue;
    task_data.old_residue = sat ? window[0] : 8'd0;
    task_data.drop        = sat;
    task_data.full        = sat || (CNT_W'(seen + CNT_W'(1)) == k);
    task_data.last        = item.last_residue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= KMER_RESET;
      seen        <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) window[i] <= 8'd0;
    end else if (cfg_write) begin
      kmer_length <= cfg_data;
      seen        <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) window[i] <= 8'd0;
    end else if (accept) begin
      if (item.last_residue) begin
        seen <= '0;
        for (int i = 0; i < MAX_WINDOW; i++) window[i] <= 8'd0;
      end else if (!sat) begin
        seen <= CNT_W'(seen + CNT_W'(1));
        for (int i = 0; i < MAX_WINDOW; i++) begin
          if (seen == CNT_W'(i)) window[i] <= item.residue;
        end
      end else begin
        // shift the window down and append
        for (int i = 0; i < MAX_WINDOW; i++) begin
          if (CNT_W'(i) == CNT_W'(k - CNT_W'(1))) begin
            window[i] <= item.residue;
          end else if (CNT_W'(i) < CNT_W'(k - CNT_W'(1))) begin
            window[i] <= window[(i + 1) % MAX_WINDOW];
          end
        end
      end
    end
  end

endmodule

// File: rtl/kmh_queue.sv
// Short task queue between the front end and the hash engine.
// Depends on kmh_pkg.
module kmh_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  kmh_pkg::task_t push_data,
  output logic           space,
  input  logic           pop,
  output logic           avail,
  output kmh_pkg::task_t pop_data
);
  import kmh_pkg::*;

  task_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign space    = (count != QCNT_W'(QUEUE_DEPTH));
  assign avail    = (count != '0);
  assign pop_data = slots[rd_ptr];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(p + QPTR_W'(1));
  endfunction

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      unique case ({push, pop})
        2'b10:   count <= QCNT_W'(count + QCNT_W'(1));
        2'b01:   count <= QCNT_W'(count - QCNT_W'(1));
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/kmh_back.sv
// Hash engine: rolling hash update, two-multiply mixer on a shared 32x32 multiplier,
// running minimum and result register. Depends on kmh_pkg.
module kmh_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [3:0]       cfg_data,
  input  logic             task_avail,
  output logic             task_pop,
  input  kmh_pkg::task_t   task_data,
  output logic             result_valid,
  input  logic             result_stall,
  output kmh_pkg::result_t result
);
  import kmh_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_DROP = 12'b0000_0000_0010,
    ST_ROLL = 12'b0000_0000_0100,
    ST_MA0  = 12'b0000_0000_1000,
    ST_MA1  = 12'b0000_0001_0000,
    ST_MA2  = 12'b0000_0010_0000,
    ST_XA   = 12'b0000_0100_0000,
    ST_MB0  = 12'b0000_1000_0000,
    ST_MB1  = 12'b0001_0000_0000,
    ST_MB2  = 12'b0010_0000_0000,
    ST_XB   = 12'b0100_0000_0000,
    ST_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t      state;
  task_t       cur;
  logic [63:0] hash;
  logic [63:0] drop_weight;
  logic [63:0] best;
  logic [63:0] acc;
  logic [63:0] op;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] mixed;
  logic        slot_free;

  assign task_pop  = (state == ST_IDLE) && task_avail;
  assign slot_free = !result_valid || !result_stall;
  assign prod      = {32'd0, mul_a} * {32'd0, mul_b};
  assign mixed     = acc ^ (acc >> MIX_SHIFT_B);

  always_comb begin
    unique case (state)
      ST_MA0:  begin mul_a = hash[31:0];  mul_b = MIX_MUL_A[31:0];  end
      ST_MA1:  begin mul_a = hash[31:0];  mul_b = MIX_MUL_A[63:32]; end
      ST_MA2:  begin mul_a = hash[63:32]; mul_b = MIX_MUL_A[31:0];  end
      ST_MB0:  begin mul_a = op[31:0];    mul_b = MIX_MUL_B[31:0];  end
      ST_MB1:  begin mul_a = op[31:0];    mul_b = MIX_MUL_B[63:32]; end
      ST_MB2:  begin mul_a = op[63:32];   mul_b = MIX_MUL_B[31:0];  end
      default: begin mul_a = 32'd0;       mul_b = 32'd0;            end
    endcase
  end

  always_ff @(posedge clk) begin
    if (task_pop) cur <= task_data;
    unique case (state)
      ST_MA0, ST_MB0:         acc <= prod;
      ST_MA1, ST_MA2,
      ST_MB1, ST_MB2:         acc <= acc + {prod[31:0], 32'd0};
      ST_XA:                  op  <= acc ^ (acc >> MIX_SHIFT_A);
      default:                acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      hash         <= 64'd0;
      best         <= '1;
      drop_weight  <= drop_weight_of(KMER_RESET);
      result_valid <= 1'b0;
    end else if (cfg_write) begin
      hash        <= 64'd0;
      best        <= '1;
      drop_weight <= drop_weight_of(cfg_data);
    end else begin
      if (state == ST_FIN && slot_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (task_avail) state <= ST_DROP;
        end
        ST_DROP: begin
          if (cur.drop) hash <= hash - drop_weight * {56'd0, cur.old_residue};
          state <= ST_ROLL;
        end
        ST_ROLL: begin
          hash <= (hash << POLY_SHIFT) + hash * {55'd0, POLY_LOW} + {56'd0, cur.residue};
          if (cur.full) begin
            state <= ST_MA0;
          end else if (cur.last) begin
            state <= ST_FIN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_MA0: state <= ST_MA1;
        ST_MA1: state <= ST_MA2;
        ST_MA2: state <= ST_XA;
        ST_XA:  state <= ST_MB0;
        ST_MB0: state <= ST_MB1;
        ST_MB1: state <= ST_MB2;
        ST_MB2: state <= ST_XB;
        ST_XB: begin
          if (mixed < best) best <= mixed;
          state <= cur.last ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          if (slot_free) begin
            hash  <= 64'd0;
            best  <= '1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && slot_free) begin
      result.anchor_hash   <= cur.full ? best : 64'd0;
      result.anchor_usable <= cur.full && (best != 64'd0) && (best != '1);
    end
  end

endmodule

// File: rtl/kmer_min_anchor_hash.sv
// Top level of the k-mer minimum anchor hash block.
// Instantiates kmh_front, kmh_queue and kmh_back; depends on kmh_pkg.
//
//  channel  | signals                            | transfer when
//  item     | item_valid, item_stall, item       | item_valid && !item_stall
//  result   | result_valid, result_stall, result | result_valid && !result_stall
//  config   | cfg_write, cfg_data                | cfg_write
//
// In the hash engine a residue passes through a pop state and two rolling-hash steps;
// once the window is full it goes on through six 32x32 partial products on the one
// shared multiplier with two xor-shift steps and the minimum; a last residue adds a
// final result state.
// The front end takes a residue each cycle while the two-entry queue has room.
// Reset is synchronous and leaves k at 12. A stalled result holds the engine at the
// last residue of the next sequence.
module kmer_min_anchor_hash (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  kmh_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output kmh_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [3:0]       cfg_data
);
  import kmh_pkg::*;

  logic  push;
  logic  space;
  logic  pop;
  logic  avail;
  task_t push_task;
  task_t pop_task;

  kmh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .task_valid (push),
    .task_ready (space),
    .task_data  (push_task)
  );

  kmh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_task),
    .space     (space),
    .pop       (pop),
    .avail     (avail),
    .pop_data  (pop_task)
  );

  kmh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .task_avail   (avail),
    .task_pop     (pop),
    .task_data    (pop_task),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// File: test/anchor_checker.sv
`timescale 1ns / 1ps
// Anchor checker for kmer_min_anchor_hash: follows window length writes and residue
// transfers, predicts each sequence's minimum mixed window hash and compares every
// result transfer against it. Depends on kmh_pkg for payload types and hash constants.
module anchor_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  kmh_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  kmh_pkg::result_t result,
  input  logic             cfg_write,
  input  logic [3:0]       cfg_data,
  output int               errors,
  output int               pending,
  output int               compared
);
  import kmh_pkg::*;

  logic [3:0]  k_raw;
  logic [63:0] roll_hash;
  logic [7:0]  window [MAX_WINDOW];
  int          filled;
  logic [63:0] oldest_weight;
  logic [63:0] min_mixed;
  result_t     anchor_q [$];
  int          err_count;
  int          done_count;

  function automatic int window_len(input logic [3:0] raw);
    if (raw == 4'd0) begin
      return 1;
    end
    if (int'(raw) > MAX_WINDOW) begin
      return MAX_WINDOW;
    end
    return int'(raw);
  endfunction

  function automatic logic [63:0] base_power(input int k);
    logic [63:0] w;
    w = 64'd1;
    for (int i = 1; i < k; i++) begin
      w = w * POLY_BASE;
    end
    return w;
  endfunction

  function automatic logic [63:0] scramble64(input logic [63:0] h);
    logic [63:0] s;
    s = h * MIX_MUL_A;
    s = s ^ (s >> MIX_SHIFT_A);
    s = s * MIX_MUL_B;
    s = s ^ (s >> MIX_SHIFT_B);
    return s;
  endfunction

  task automatic restart_sequence();
    roll_hash = 64'd0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      window[i] = 8'd0;
    end
    filled    = 0;
    min_mixed = '1;
  endtask

  task automatic absorb_residue(input item_t it);
    int          k;
    logic        full;
    logic [63:0] anchor;
    result_t     want;
    k = window_len(k_raw);
    if (filled < k) begin
      roll_hash      = roll_hash * POLY_BASE + {56'd0, it.residue};
      window[filled] = it.residue;
      filled++;
      full = (filled == k);
    end else begin
      roll_hash = roll_hash - oldest_weight * {56'd0, window[0]};
      roll_hash = roll_hash * POLY_BASE + {56'd0, it.residue};
      for (int i = 1; i < k; i++) begin
        window[i-1] = window[i];
      end
      window[k-1] = it.residue;
      full = 1'b1;
    end
    if (full && scramble64(roll_hash) < min_mixed) begin
      min_mixed = scramble64(roll_hash);
    end
    if (it.last_residue) begin
      anchor = (filled < k) ? 64'd0 : min_mixed;
      want.anchor_hash   = anchor;
      want.anchor_usable = (anchor != 64'd0) && (anchor != '1);
      anchor_q.insert(anchor_q.size(), want);
      restart_sequence();
    end
  endtask

  task automatic check_anchor(input result_t got);
    result_t want;
    if (anchor_q.size() == 0) begin
      err_count++;
      if (err_count <= 10) begin
        $display("unexpected anchor transfer: hash %h usable %b",
                 got.anchor_hash, got.anchor_usable);
      end
    end else begin
      want = anchor_q.pop_front();
      done_count++;
      if (got.anchor_hash !== want.anchor_hash ||
          got.anchor_usable !== want.anchor_usable) begin
        err_count++;
        if (err_count <= 10) begin
          $display("anchor %0d wrong: got hash %h usable %b, want hash %h usable %b",
                   done_count, got.anchor_hash, got.anchor_usable,
                   want.anchor_hash, want.anchor_usable);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      k_raw         = KMER_RESET;
      oldest_weight = base_power(window_len(KMER_RESET));
      restart_sequence();
      anchor_q.delete();
      err_count  = 0;
      done_count = 0;
    end else begin
      if (cfg_write) begin
        k_raw         = cfg_data;
        oldest_weight = base_power(window_len(cfg_data));
        restart_sequence();
      end
      if (result_valid && !result_stall) begin
        check_anchor(result);
      end
      if (item_valid && !item_stall) begin
        absorb_residue(item);
      end
    end
    errors   <= err_count;
    pending  <= anchor_q.size();
    compared <= done_count;
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Top of the kmer_min_anchor_hash testbench: clock, reset, residue and window length
// stimulus, result stall pattern, watchdog and verdict.
// Depends on kmh_pkg, the kmer_min_anchor_hash block and anchor_checker.
module testbench;
  import kmh_pkg::*;

  localparam int DRAIN     = 80;
  localparam int HOLD_SPAN = 300;
  localparam int LIMIT     = 4000;
  localparam int RUN_ITEMS = 400;
  localparam int RUN_SEQS  = 24;
  localparam logic [31:0] K_PLAN = {4'd3, 4'd7, 4'd12, 4'd2, 4'd13, 4'd15, 4'd0, 4'd1};

  typedef enum int {FILL_RANDOM, FILL_BASES, FILL_REPEAT, FILL_EXTREMES} fill_t;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  item_t      item;
  logic       result_valid;
  logic       result_stall;
  result_t    result;
  logic       cfg_write;
  logic [3:0] cfg_data;
  logic       idle_on;
  logic       hold_req;
  int         errors;
  int         pending;
  int         compared;
  int         residues_sent;
  int         sequences_sent;
  int         k_writes;
  int         k_now;

  kmer_min_anchor_hash dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  anchor_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .compared     (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input logic [7:0] r, input logic fin);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{residue: r, last_residue: fin};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    residues_sent++;
    if (fin) begin
      sequences_sent++;
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_k(input logic [3:0] v);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (v == 4'd0) begin
      k_now = 1;
    end else if (int'(v) > MAX_WINDOW) begin
      k_now = MAX_WINDOW;
    end else begin
      k_now = int'(v);
    end
    k_writes++;
  endtask

  task automatic send_random_seq();
    int          len;
    logic [7:0]  fill;
    logic [7:0]  r;
    fill_t       flavor;
    case ($urandom_range(0, 3))
      0: len = $urandom_range(1, k_now);
      1, 2: len = $urandom_range(k_now, k_now + 10);
      default: len = $urandom_range(k_now + 10, k_now + 30);
    endcase
    flavor = fill_t'($urandom_range(0, 3));
    fill   = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      case (flavor)
        FILL_BASES: begin
          case ($urandom_range(0, 3))
            0: r = 8'h41;
            1: r = 8'h43;
            2: r = 8'h47;
            default: r = 8'h54;
          endcase
        end
        FILL_REPEAT: r = fill;
        FILL_EXTREMES: r = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        default: r = 8'($urandom);
      endcase
      send_item(r, i == len - 1);
    end
  endtask

  initial begin : result_sink
    bit held;
    held         = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        result_stall <= 1'b1;
        for (int n = 0; n < HOLD_SPAN; n++) @(posedge clk);
        result_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no transfer for %0d cycles", LIMIT);
    $display("kmer_min_anchor_hash: mismatch");
    $finish;
  end

  initial begin : stimulus
    int         phase;
    int         nseq;
    logic [3:0] v;
    rst            = 1'b1;
    item_valid     = 1'b0;
    item           = '0;
    cfg_write      = 1'b0;
    cfg_data       = 4'd0;
    idle_on        = 1'b1;
    hold_req       = 1'b0;
    residues_sent  = 0;
    sequences_sent = 0;
    k_writes       = 0;
    k_now          = MAX_WINDOW;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short sequence at the reset window length
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h5a, 1'b1);
    // single-residue windows, zero hash gives a zero anchor
    write_k(4'd1);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    // restart the open sequence with a window length write
    send_item(8'h12, 1'b0);
    send_item(8'h34, 1'b0);
    write_k(4'd2);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b1);
    // out-of-range window lengths clamp
    write_k(4'd0);
    send_item(8'h07, 1'b0);
    send_item(8'h08, 1'b1);
    write_k(4'd15);
    for (int i = 0; i < 13; i++) begin
      send_item(8'($urandom), i == 12);
    end

    phase = 0;
    while (residues_sent < RUN_ITEMS || sequences_sent < RUN_SEQS) begin
      v = (phase < 8) ? K_PLAN[phase*4 +: 4] : 4'($urandom_range(0, 15));
      write_k(v);
      idle_on <= ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        hold_req <= 1'b1;
      end
      nseq = $urandom_range(4, 8);
      for (int s = 0; s < nseq; s++) begin
        if (phase == 4 && s == 2) begin
          settle();
        end
        send_random_seq();
      end
      phase++;
    end

    // final stretch without idling on either side
    idle_on <= 1'b0;
    write_k(4'($urandom_range(1, 12)));
    for (int s = 0; s < 4; s++) begin
      send_random_seq();
    end
    settle();

    $display("covered %0d residues in %0d sequences over %0d window length writes",
             residues_sent, sequences_sent, k_writes);
    $display("%0d anchors compared, %0d failures, %0d anchors missing",
             compared, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("kmer_min_anchor_hash: match");
    end else begin
      $display("kmer_min_anchor_hash: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/kmh_pkg.sv
rtl/kmh_front.sv
rtl/kmh_queue.sv
rtl/kmh_back.sv
rtl/kmer_min_anchor_hash.sv
test/anchor_checker.sv
test/testbench.sv
